### src/mmf_pkg.sv
`default_nettype none

package mmf_pkg;

    // Framer phase: outside a message, inside a fixed-length message, inside sysex.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIXED,
        PH_SYSEX
    } mmf_phase_t;

    // Result classification codes.
    localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_OTHER    = 2'd2;

    // Status byte values and message types.
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_TIME_CODE   = 8'hF1;
    localparam logic [7:0] ST_SONG_SELECT = 8'hF3;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [3:0] TYPE_NOTE_OFF  = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON   = 4'h9;
    localparam logic [3:0] TYPE_SYSTEM    = 4'hF;

    // Port widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_status;
        logic       opens_sysex;
        logic       single;
        logic [1:0] init_left;
    } mmf_entry_t;

    // Bytes owed after a channel status byte, indexed by the status type minus 8.
    function automatic logic [1:0] chan_left(input logic [2:0] idx);
        logic [1:0] left;
        case (idx)
            3'd4, 3'd5: left = 2'd1;
            default:    left = 2'd2;
        endcase
        return left;
    endfunction

endpackage

`default_nettype wire

### src/mmf_front.sv
`default_nettype none

// Front end: takes bytes from the input channel, classifies each status byte
// and pushes the classified word into the queue.
module mmf_front (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mmf_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tlast,
    input  wire logic                          q_full,
    output logic                               q_push,
    output mmf_pkg::mmf_entry_t                q_wdata
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Work out from the status byte how long its message is.
    always_comb begin
        q_wdata             = '0;
        q_wdata.data        = s_tdata;
        q_wdata.last        = s_tlast;
        q_wdata.is_status   = s_tdata[7];
        if (s_tdata[7:4] != mmf_pkg::TYPE_SYSTEM) begin
            q_wdata.init_left = mmf_pkg::chan_left(s_tdata[6:4]);
        end else if (s_tdata == mmf_pkg::ST_SYSEX_START) begin
            q_wdata.opens_sysex = 1'b1;
        end else if (s_tdata == mmf_pkg::ST_TIME_CODE
                     || s_tdata == mmf_pkg::ST_SONG_SELECT) begin
            q_wdata.init_left = 2'd1;
        end else if (s_tdata == mmf_pkg::ST_SONG_POS) begin
            q_wdata.init_left = 2'd2;
        end else begin
            q_wdata.single = 1'b1;
        end
    end

endmodule

`default_nettype wire

### src/mmf_fifo.sv
`default_nettype none

// Short queue of classified words between the front and the back.
module mmf_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire mmf_pkg::mmf_entry_t wdata,
    output logic                     full,
    input  wire logic                pop,
    output mmf_pkg::mmf_entry_t      rdata,
    output logic                     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mmf_pkg::mmf_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

### src/mmf_back.sv
`default_nettype none

// Back end: runs the message framer on queued words and holds each finished
// message in an output register until the receiver takes it.
module mmf_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_empty,
    input  wire mmf_pkg::mmf_entry_t           q_rdata,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mmf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [mmf_pkg::M_TUSER_W-1:0]      m_tuser
);

    mmf_pkg::mmf_phase_t phase_reg, phase_next;
    logic [1:0]          left_reg, left_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [7:0]          b0_reg, b1_reg, b2_reg;
    logic [7:0]          b0_next, b1_next, b2_next;
    logic [1:0]          left_dec;
    logic                emit;

    logic                                 valid_reg, valid_next;
    logic [mmf_pkg::M_TDATA_W-1:0]        tdata_reg, tdata_next;
    logic [mmf_pkg::M_TUSER_W-1:0]        tuser_reg, tuser_next;
    logic [1:0]                           kind;

    // A word leaves the queue whenever the output register is free or drains.
    assign q_pop    = !q_empty && (!valid_reg || m_tready);
    assign left_dec = (left_reg != 2'd0) ? left_reg - 2'd1 : 2'd0;

    // Capture the word into the message bytes and decide whether it closes the message.
    always_comb begin
        cnt_next  = cnt_reg;
        b0_next   = b0_reg;
        b1_next   = b1_reg;
        b2_next   = b2_reg;
        left_next = left_reg;
        emit      = 1'b0;
        if (q_pop) begin
            case (phase_reg)
                mmf_pkg::PH_FIXED, mmf_pkg::PH_SYSEX: begin
                    if (cnt_reg != 2'd3) begin
                        case (cnt_reg)
                            2'd0:    b0_next = q_rdata.data;
                            2'd1:    b1_next = q_rdata.data;
                            default: b2_next = q_rdata.data;
                        endcase
                        cnt_next = cnt_reg + 2'd1;
                    end
                    if (phase_reg == mmf_pkg::PH_FIXED) begin
                        left_next = left_dec;
                        emit      = (left_dec == 2'd0) || q_rdata.last;
                    end else begin
                        emit = (q_rdata.data == mmf_pkg::ST_SYSEX_END) || q_rdata.last;
                    end
                end
                default: begin
                    if (q_rdata.is_status) begin
                        cnt_next  = 2'd1;
                        b0_next   = q_rdata.data;
                        b1_next   = 8'd0;
                        b2_next   = 8'd0;
                        left_next = q_rdata.init_left;
                        emit      = q_rdata.single || q_rdata.last;
                    end
                end
            endcase
        end
    end

    // Next phase of the framer.
    always_comb begin
        phase_next = phase_reg;
        if (q_pop) begin
            if (emit) begin
                phase_next = mmf_pkg::PH_IDLE;
            end else begin
                case (phase_reg)
                    mmf_pkg::PH_FIXED: phase_next = mmf_pkg::PH_FIXED;
                    mmf_pkg::PH_SYSEX: phase_next = mmf_pkg::PH_SYSEX;
                    default: begin
                        if (q_rdata.is_status) begin
                            phase_next = q_rdata.opens_sysex ? mmf_pkg::PH_SYSEX
                                                             : mmf_pkg::PH_FIXED;
                        end else begin
                            phase_next = mmf_pkg::PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    // Classify the finished message and load the output register.
    always_comb begin
        kind = mmf_pkg::KIND_OTHER;
        if (b0_next[7:4] == mmf_pkg::TYPE_NOTE_ON) begin
            kind = (b2_next != 8'd0) ? mmf_pkg::KIND_NOTE_ON : mmf_pkg::KIND_NOTE_OFF;
        end else if (b0_next[7:4] == mmf_pkg::TYPE_NOTE_OFF) begin
            kind = mmf_pkg::KIND_NOTE_OFF;
        end
        valid_next = valid_reg;
        tdata_next = tdata_reg;
        tuser_next = tuser_reg;
        if (q_pop && emit) begin
            valid_next = 1'b1;
            tuser_next = kind;
            tdata_next = {2'b00, b2_next, b1_next, b0_next, cnt_next,
                          b2_next, b1_next, b0_next[3:0]};
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mmf_pkg::PH_IDLE;
            left_reg  <= 2'd0;
            cnt_reg   <= 2'd0;
            b0_reg    <= 8'd0;
            b1_reg    <= 8'd0;
            b2_reg    <= 8'd0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
            if (q_pop && emit) begin
                left_reg <= 2'd0;
                cnt_reg  <= 2'd0;
                b0_reg   <= 8'd0;
                b1_reg   <= 8'd0;
                b2_reg   <= 8'd0;
            end else begin
                left_reg <= left_next;
                cnt_reg  <= cnt_next;
                b0_reg   <= b0_next;
                b1_reg   <= b1_next;
                b2_reg   <= b2_next;
            end
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge aclk) begin
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

`default_nettype wire

### src/midi_message_framer_unit.sv
`default_nettype none

// MIDI message framer.
// Input channel (s_): one raw MIDI byte per word in s_tdata; s_tlast marks the
// last byte of a host buffer and cuts any open message short.
// Output channel (m_): one word per finished message. m_tuser carries the kind
// (note on, note off, other); m_tdata carries channel, key, velocity, byte count,
// status byte and the two data bytes.
// Throughput: one byte per cycle while the queue is not full. A front stage
// classifies each accepted byte into a FIFO_DEPTH-entry queue; the back stage
// takes one queued byte per cycle while the output register is free or taken.
// Path: the closing byte of a message is written into the queue, then framed
// and loaded into the output register that drives m_tvalid.
// Receiver stall: the output register holds the message; the back stage stops
// draining the queue while it holds an untaken message, and the queue absorbs
// up to FIFO_DEPTH bytes before s_tready drops.
// Reset: aresetn low on a rising edge empties the queue, drops any partly
// framed message and the held result, and leaves the framer outside a message.
module midi_message_framer_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mmf_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] channel, [11:4] key, [19:12] velocity, [21:20] byte_count,
    // [29:22] status_byte, [37:30] data_one, [45:38] data_two, [47:46] zero
    output logic [mmf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [mmf_pkg::M_TUSER_W-1:0]      m_tuser    // [1:0] kind
);

    mmf_pkg::mmf_entry_t q_wdata, q_rdata;
    logic                q_push, q_pop, q_full, q_empty;

    mmf_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    mmf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    mmf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### src/mmf_checker.sv
`default_nettype none

// Port-level checks on the framer's result channel.
module mmf_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mmf_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [mmf_pkg::M_TUSER_W-1:0] m_tuser
);

    // Nothing is offered in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word offered right after reset");

    // A stalled result word holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // Every message starts with a status byte and holds at least one byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[29] && m_tdata[21:20] != 2'd0 && m_tdata[47:46] == 2'd0)
        else $error("malformed message word");

    // A note on is a 9n status with nonzero velocity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mmf_pkg::KIND_NOTE_ON
        |-> m_tdata[29:26] == mmf_pkg::TYPE_NOTE_ON && m_tdata[19:12] != 8'd0)
        else $error("note on classification wrong");

    // A note off is an 8n status, or a 9n status with zero velocity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mmf_pkg::KIND_NOTE_OFF
        |-> m_tdata[29:26] == mmf_pkg::TYPE_NOTE_OFF
            || (m_tdata[29:26] == mmf_pkg::TYPE_NOTE_ON && m_tdata[19:12] == 8'd0))
        else $error("note off classification wrong");

endmodule

bind midi_message_framer_unit mmf_checker u_mmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
